[rtl/core/jac_pkg.sv]
// ----------------------------------------------------------------------------
// jac_pkg
// Types, codes and constants shared by the joystick axis calibrator.
// ----------------------------------------------------------------------------
package jac_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int SAMPLE_W     = 12;
	localparam int CH_W         = 4;
	localparam int POS_W        = 16;
	localparam int OFF_W        = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 15;
	localparam int DIV_NUM_W    = 31;
	localparam int DIV_DEN_W    = 16;

	localparam logic signed [POS_W-1:0] LIM_POS = 16'sd32767;
	localparam logic signed [POS_W-1:0] LIM_NEG = -16'sd32767;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_ZERO   = 2'd1,
		CMD_LIMITS = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CALIBRATE = 3'd0,
		REG_ALPHA     = 3'd1,
		REG_DEAD_ZONE = 3'd2,
		REG_TRIM      = 3'd3,
		REG_FULL      = 3'd4,
		REG_DIVIDER   = 3'd5,
		REG_DIRECTION = 3'd6,
		REG_SPARE     = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_FILT, ST_CENTER, ST_SPAN, ST_SPAN_WAIT,
		ST_MUL, ST_QUOT, ST_QUOT_WAIT, ST_POST, ST_DONE
	} state_t;

	typedef struct packed {
		logic                  calibrate;
		logic [8:0]            alpha;
		logic [11:0]           dead_zone;
		logic signed [12:0]    trim;
		logic [14:0]           full_scale;
		logic [7:0]            divider;
		logic signed [1:0]     direction;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]        sm;
		logic signed [OFF_W-1:0]    off;
		logic signed [POS_W-1:0]    low;
		logic signed [POS_W-1:0]    high;
		logic signed [POS_W-1:0]    pos;
	} ent_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic filt;
		logic center;
		logic span_go;
		logic span_take;
		logic mul;
		logic quot_go;
		logic quot_take;
		logic post;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic is_sample;
		logic bad;
		logic calibrate;
		logic fault;
		logic div_done;
		logic out_pending;
	} sts_t;

endpackage

[rtl/core/jac_regs.sv]
// ----------------------------------------------------------------------------
// jac_regs
// Shared configuration registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module jac_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jac_pkg::CFG_DATA_W-1:0]  cfg_data,
	output jac_pkg::cfg_t                   cfg
);
	import jac_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calibrate  <= 1'b0;
			cfg_q.alpha      <= 9'd64;
			cfg_q.dead_zone  <= '0;
			cfg_q.trim       <= '0;
			cfg_q.full_scale <= 15'd1000;
			cfg_q.divider    <= 8'd1;
			cfg_q.direction  <= 2'sd1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CALIBRATE: cfg_q.calibrate  <= cfg_data[0];
				REG_ALPHA:     cfg_q.alpha      <= cfg_data[8:0];
				REG_DEAD_ZONE: cfg_q.dead_zone  <= cfg_data[11:0];
				REG_TRIM:      cfg_q.trim       <= $signed(cfg_data[12:0]);
				REG_FULL:      cfg_q.full_scale <= cfg_data[14:0];
				REG_DIVIDER:   cfg_q.divider    <= cfg_data[7:0];
				REG_DIRECTION: cfg_q.direction  <= $signed(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/jac_div.sv]
// ----------------------------------------------------------------------------
// jac_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jac_div #(
	parameter int NW = jac_pkg::DIV_NUM_W,
	parameter int DW = jac_pkg::DIV_DEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW+1:0] trial;

	assign trial = {1'b0, rem_q, quo_q[NW-1]} - {2'b00, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

endmodule

[rtl/core/jac_datapath.sv]
// ----------------------------------------------------------------------------
// jac_datapath
// Channel state memory, filter, centering, mapping arithmetic and result
// register.
// ----------------------------------------------------------------------------
module jac_datapath #(
	parameter int CHANNELS = jac_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jac_pkg::cfg_t                       cfg,
	input  jac_pkg::ctl_t                       ctl,
	output jac_pkg::sts_t                       sts,
	input  logic [1:0]                          in_cmd,
	input  logic [jac_pkg::CH_W-1:0]            in_channel,
	input  logic [jac_pkg::SAMPLE_W-1:0]        in_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [jac_pkg::CH_W-1:0]            out_channel,
	output logic [jac_pkg::SAMPLE_W-1:0]        filtered,
	output logic signed [jac_pkg::POS_W-1:0]    position,
	output logic signed [jac_pkg::POS_W-1:0]    learned_low,
	output logic signed [jac_pkg::POS_W-1:0]    learned_high,
	output logic                                limit_fault
);
	import jac_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	ent_t                   mem [CHANNELS];
	logic [CHANNELS-1:0]    vld_q;
	ent_t                   rd_q;
	logic                   rd_vld_q;
	ent_t                   ent;

	cmd_t                   cmd_q;
	logic [CH_W-1:0]        ch_q;
	logic [SAMPLE_W-1:0]    raw_q;
	logic                   bad;
	logic [AW-1:0]          addr;

	logic [SAMPLE_W-1:0]        sm_q;
	logic signed [OFF_W-1:0]    off_q;
	logic signed [POS_W-1:0]    low_q;
	logic signed [POS_W-1:0]    high_q;
	logic signed [POS_W-1:0]    pos_q;
	logic                       fault_q;
	logic signed [14:0]         x_q;
	logic                       pside_q;
	logic [DIV_DEN_W-1:0]       d_q;
	logic [14:0]                span_q;
	logic [DIV_NUM_W-1:0]       mag_q;
	logic                       neg_q;

	logic signed [12:0]     diff;
	logic [9:0]             alpha_eff;
	logic signed [22:0]     ema_prod;
	logic signed [13:0]     sm_sum;
	logic signed [13:0]     v;
	logic signed [14:0]     dz;
	logic signed [14:0]     xv;
	logic signed [16:0]     dsel;
	logic signed [16:0]     mul_a;
	logic signed [32:0]     mul_p;
	logic signed [32:0]     mul_abs;
	logic signed [31:0]     sq;
	logic signed [31:0]     span_s;
	logic signed [31:0]     pv;
	logic signed [31:0]     pdir;

	logic                   div_start;
	logic [DIV_NUM_W-1:0]   div_num;
	logic [DIV_DEN_W-1:0]   div_den;
	logic                   div_done;
	logic [DIV_NUM_W-1:0]   div_quo;

	logic                   ov_q;
	logic [CH_W-1:0]        och_q;
	logic [SAMPLE_W-1:0]    ofilt_q;
	logic signed [POS_W-1:0] opos_q;
	logic signed [POS_W-1:0] olow_q;
	logic signed [POS_W-1:0] ohigh_q;
	logic                   ofault_q;

	assign addr = AW'(ch_q);
	assign bad  = (7'(ch_q) >= 7'(CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.finish && !bad) begin
			vld_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish && !bad) begin
			mem[addr] <= '{sm: sm_q, off: off_q, low: low_q, high: high_q, pos: pos_q};
		end
		if (ctl.rd) begin
			rd_q     <= mem[addr];
			rd_vld_q <= vld_q[addr];
		end
	end

	always_comb begin
		if (rd_vld_q) begin
			ent = rd_q;
		end else begin
			ent = '{sm: '0, off: '0, low: LIM_POS, high: LIM_NEG, pos: '0};
		end
	end

	assign alpha_eff = cfg.alpha[8] ? 10'd256 : {1'b0, cfg.alpha};
	assign diff      = $signed({1'b0, raw_q}) - $signed({1'b0, ent.sm});
	assign ema_prod  = diff * $signed(alpha_eff);
	assign sm_sum    = $signed({2'b00, ent.sm}) + 14'(ema_prod >>> 8);

	assign v  = $signed({2'b00, sm_q}) + 14'(off_q);
	assign dz = $signed({3'b000, cfg.dead_zone});
	always_comb begin
		if ((15'(v) < dz) && (15'(v) > -dz)) begin
			xv = 15'(cfg.trim);
		end else begin
			xv = 15'(v) + 15'(cfg.trim);
		end
		if (xv > 15'sd0) begin
			dsel = 17'(high_q);
		end else begin
			dsel = -17'(low_q);
		end
	end

	assign mul_a   = pside_q ? 17'(x_q) : (17'(x_q) - 17'(low_q));
	assign mul_p   = mul_a * $signed({1'b0, span_q});
	assign mul_abs = mul_p[32] ? -mul_p : mul_p;

	assign span_s = $signed({17'd0, span_q});
	always_comb begin
		sq = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		if (pside_q) begin
			pv = (sq > span_s) ? span_s : sq;
		end else begin
			pv = ((sq - span_s) < -span_s) ? -span_s : (sq - span_s);
		end
		case (cfg.direction)
			2'sd1:   pdir = pv;
			-2'sd1:  pdir = -pv;
			default: pdir = '0;
		endcase
	end

	assign div_start = ctl.span_go || ctl.quot_go;
	assign div_num   = ctl.span_go ? DIV_NUM_W'(cfg.full_scale) : mag_q;
	assign div_den   = ctl.span_go ? ((cfg.divider == 8'd0) ? 16'd1 : 16'(cfg.divider)) : d_q;

	jac_div #(
		.NW (DIV_NUM_W),
		.DW (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(in_cmd);
			ch_q  <= in_channel;
			raw_q <= in_sample;
		end
		if (ctl.filt) begin
			sm_q    <= ent.sm;
			off_q   <= ent.off;
			low_q   <= ent.low;
			high_q  <= ent.high;
			pos_q   <= ent.pos;
			fault_q <= 1'b0;
			unique case (cmd_q)
				CMD_SAMPLE: sm_q <= sm_sum[SAMPLE_W-1:0];
				CMD_ZERO:   off_q <= -$signed({1'b0, ent.sm});
				CMD_LIMITS: begin
					low_q  <= LIM_POS;
					high_q <= LIM_NEG;
				end
				default: ;
			endcase
		end
		if (ctl.center) begin
			if (cfg.calibrate) begin
				if (16'(v) < low_q) begin
					low_q <= 16'(v);
				end else if (16'(v) > high_q) begin
					high_q <= 16'(v);
				end
			end else begin
				x_q     <= xv;
				pside_q <= (xv > 15'sd0);
				d_q     <= dsel[DIV_DEN_W-1:0];
				fault_q <= (dsel <= 17'sd0);
			end
		end
		if (ctl.span_take) begin
			span_q <= div_quo[14:0];
		end
		if (ctl.mul) begin
			mag_q <= mul_abs[DIV_NUM_W-1:0];
			neg_q <= mul_p[32];
		end
		if (ctl.post) begin
			pos_q <= fault_q ? '0 : pdir[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctl.finish) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			och_q    <= ch_q;
			ofilt_q  <= bad ? '0 : sm_q;
			opos_q   <= bad ? '0 : pos_q;
			olow_q   <= bad ? '0 : low_q;
			ohigh_q  <= bad ? '0 : high_q;
			ofault_q <= bad ? 1'b0 : fault_q;
		end
	end

	assign out_valid    = ov_q;
	assign out_channel  = och_q;
	assign filtered     = ofilt_q;
	assign position     = opos_q;
	assign learned_low  = olow_q;
	assign learned_high = ohigh_q;
	assign limit_fault  = ofault_q;

	assign sts.is_sample   = (cmd_q == CMD_SAMPLE);
	assign sts.bad         = bad;
	assign sts.calibrate   = cfg.calibrate;
	assign sts.fault       = fault_q;
	assign sts.div_done    = div_done;
	assign sts.out_pending = ov_q && !out_ready;

endmodule

[rtl/core/jac_ctrl.sv]
// ----------------------------------------------------------------------------
// jac_ctrl
// Sequencer that steps one item through the datapath.
// ----------------------------------------------------------------------------
module jac_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jac_pkg::sts_t   sts,
	output jac_pkg::ctl_t   ctl,
	output logic            idle
);
	import jac_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_READ;
			ST_READ:      state_d = ST_FILT;
			ST_FILT:      state_d = (sts.bad || !sts.is_sample) ? ST_DONE : ST_CENTER;
			ST_CENTER:    state_d = sts.calibrate ? ST_DONE : ST_SPAN;
			ST_SPAN:      state_d = ST_SPAN_WAIT;
			ST_SPAN_WAIT: if (sts.div_done) state_d = sts.fault ? ST_POST : ST_MUL;
			ST_MUL:       state_d = ST_QUOT;
			ST_QUOT:      state_d = ST_QUOT_WAIT;
			ST_QUOT_WAIT: if (sts.div_done) state_d = ST_POST;
			ST_POST:      state_d = ST_DONE;
			ST_DONE:      if (!sts.out_pending) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_READ:      ctl.rd = 1'b1;
			ST_FILT:      ctl.filt = 1'b1;
			ST_CENTER:    ctl.center = 1'b1;
			ST_SPAN:      ctl.span_go = 1'b1;
			ST_SPAN_WAIT: ctl.span_take = sts.div_done;
			ST_MUL:       ctl.mul = 1'b1;
			ST_QUOT:      ctl.quot_go = 1'b1;
			ST_QUOT_WAIT: ctl.quot_take = sts.div_done;
			ST_POST:      ctl.post = 1'b1;
			ST_DONE:      ctl.finish = !sts.out_pending;
			default: ;
		endcase
	end

	assign idle = (state_q == ST_IDLE);

endmodule

[rtl/core/joystick_axis_calibrator.sv]
// ----------------------------------------------------------------------------
// joystick_axis_calibrator
// One item is a sample, zero capture or limit reset for one channel and
// returns one result item with that channel's current state. A sample in
// normal mode makes two passes of the 31-step shift-subtract divider
// (output span, then the mapping quotient); when the learned limit faults,
// the mapping pass is skipped. A sample in calibrate mode and the other
// commands bypass the divider. The block works on one item at a time; a
// finished result waits in the output register while the next item is
// taken, and that item holds before its own result until the register is
// free.
// ----------------------------------------------------------------------------
module joystick_axis_calibrator #(
	parameter int CHANNELS = jac_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,  // channel, sample
	input  logic [1:0]                      s_tuser,  // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_channel, filtered, position, learned_low, learned_high
	output logic [63:0]                     m_tdata,
	output logic                            m_tuser,  // limit_fault
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jac_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import jac_pkg::*;

	cfg_t                   cfg;
	ctl_t                   ctl;
	sts_t                   sts;
	logic                   idle;
	logic [CH_W-1:0]        out_channel;
	logic [SAMPLE_W-1:0]    filtered;
	logic signed [POS_W-1:0] position;
	logic signed [POS_W-1:0] learned_low;
	logic signed [POS_W-1:0] learned_high;

	jac_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl),
		.idle     (idle)
	);

	jac_datapath #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctl          (ctl),
		.sts          (sts),
		.in_cmd       (s_tuser),
		.in_channel   (s_tdata[3:0]),
		.in_sample    (s_tdata[15:4]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_channel  (out_channel),
		.filtered     (filtered),
		.position     (position),
		.learned_low  (learned_low),
		.learned_high (learned_high),
		.limit_fault  (m_tuser)
	);

	assign m_tdata = {learned_high, learned_low, position, filtered, out_channel};

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (position == '0))
		else $error("fault result with nonzero position");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !idle)
		else $error("second item taken while one is in work");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten before taken");

endmodule

[tb/joystick_axis_calibrator_test.sv]
// ----------------------------------------------------------------------------
// joystick_axis_calibrator_test
// Drives commands into the axis calibrator with random gaps on both streams,
// predicts every result item from a model of the per-channel state and the
// shared settings, and compares each result field by field. Settings change
// between phases only while the block is idle.
// ----------------------------------------------------------------------------
module joystick_axis_calibrator_test;
	import jac_pkg::*;

	typedef struct packed {
		logic [3:0]         ch;
		logic [11:0]        filt;
		logic signed [15:0] pos;
		logic signed [15:0] low;
		logic signed [15:0] high;
		logic               fault;
	} axis_res_t;

	class axis_scoreboard;
		logic [11:0]        sm [16];
		logic signed [12:0] off [16];
		logic signed [15:0] low [16];
		logic signed [15:0] high [16];
		logic signed [15:0] pos [16];
		logic               calib;
		int                 alpha, dz, trim, full, divider, dir;
		axis_res_t          pending [$];
		int                 errors;

		function void clear();
			for (int i = 0; i < 16; i++) begin
				sm[i] = 0; off[i] = 0; low[i] = LIM_POS; high[i] = LIM_NEG; pos[i] = 0;
			end
			calib = 0; alpha = 64; dz = 0; trim = 0; full = 1000; divider = 1; dir = 1;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [14:0] val);
			case (idx)
				REG_CALIBRATE: calib = val[0];
				REG_ALPHA: alpha = val[8:0];
				REG_DEAD_ZONE: dz = val[11:0];
				REG_TRIM: trim = $signed(val[12:0]);
				REG_FULL: full = val[14:0];
				REG_DIVIDER: divider = val[7:0];
				REG_DIRECTION: dir = $signed(val[1:0]);
				default: ;
			endcase
		endfunction

		function void note_command(cmd_t cmd, logic [3:0] ch, logic [11:0] raw);
			axis_res_t r;
			longint a, old, v, x, p, d, span, dr, n;
			logic flt;
			flt = 0;
			if (cmd == CMD_SAMPLE) begin
				a = alpha > 256 ? 256 : alpha;
				old = sm[ch];
				n = (longint'(raw) - old) * a;
				n = n < 0 ? -((-n + 255) / 256) : n / 256;
				sm[ch] = old + n;
				v = longint'(sm[ch]) + off[ch];
				if (calib) begin
					if (v < low[ch]) low[ch] = v;
					else if (v > high[ch]) high[ch] = v;
				end else begin
					span = full / (divider == 0 ? 1 : divider);
					dr = dir == -2 ? 0 : dir;
					x = v;
					p = 0;
					if (x < dz && x > -dz) x = 0;
					x += trim;
					if (x > 0) begin
						d = high[ch];
						if (d <= 0) flt = 1;
						else begin
							n = x * span;
							p = n < 0 ? -((-n) / d) : n / d;
							if (p > span) p = span;
						end
					end else begin
						d = -longint'(low[ch]);
						if (d <= 0) flt = 1;
						else begin
							n = (x - low[ch]) * span;
							p = (n < 0 ? -((-n) / d) : n / d) - span;
							if (p < -span) p = -span;
						end
					end
					if (flt) p = 0;
					pos[ch] = p * dr;
				end
			end else if (cmd == CMD_ZERO) begin
				off[ch] = -$signed({1'b0, sm[ch]});
			end else if (cmd == CMD_LIMITS) begin
				low[ch] = LIM_POS;
				high[ch] = LIM_NEG;
			end
			r.ch = ch; r.filt = sm[ch]; r.pos = pos[ch];
			r.low = low[ch]; r.high = high[ch]; r.fault = flt;
			pending.push_back(r);
		endfunction

		function void check_result(axis_res_t got);
			axis_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.ch !== e.ch) begin
				$display("%0t: channel expected %0d actual %0d", $time, e.ch, got.ch);
				errors++;
			end
			if (got.filt !== e.filt) begin
				$display("%0t: filtered expected %0d actual %0d", $time, e.filt, got.filt);
				errors++;
			end
			if (got.pos !== e.pos) begin
				$display("%0t: position expected %0d actual %0d", $time, e.pos, got.pos);
				errors++;
			end
			if (got.low !== e.low) begin
				$display("%0t: learned_low expected %0d actual %0d", $time, e.low, got.low);
				errors++;
			end
			if (got.high !== e.high) begin
				$display("%0t: learned_high expected %0d actual %0d", $time, e.high, got.high);
				errors++;
			end
			if (got.fault !== e.fault) begin
				$display("%0t: limit_fault expected %0d actual %0d", $time, e.fault, got.fault);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic [63:0] m_tdata;
	logic        cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	axis_scoreboard sb;

	joystick_axis_calibrator dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic write_reg(reg_idx_t idx, logic [14:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_item(cmd_t cmd, logic [3:0] ch, logic [11:0] raw);
		int gap;
		gap = $urandom_range(3) == 0 ? 0 : $urandom_range(18);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1; s_tuser <= cmd; s_tdata <= {raw, ch};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, ch, raw);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_settings(bit wide);
		write_reg(REG_ALPHA, wide ? 15'($urandom_range(511)) : 15'($urandom_range(1, 256)));
		write_reg(REG_DEAD_ZONE, $urandom_range(3) == 0 ? 15'($urandom_range(4095))
			: 15'($urandom_range(300)));
		write_reg(REG_TRIM, 15'($urandom_range(8191)));
		write_reg(REG_FULL, 15'($urandom_range(32767)));
		write_reg(REG_DIVIDER, wide ? 15'($urandom_range(255)) : 15'($urandom_range(1, 255)));
		write_reg(REG_DIRECTION, 15'($urandom_range(3)));
	endtask

	task automatic random_burst(int count);
		int r;
		cmd_t c;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			c = r < 80 ? CMD_SAMPLE : r < 88 ? CMD_ZERO : r < 95 ? CMD_LIMITS : CMD_NONE;
			send_item(c, 4'($urandom_range(15)), 12'($urandom_range(4095)));
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// fault on fresh limits, then extremes of the raw range
		send_item(CMD_SAMPLE, 4'd0, 12'hFFF);
		send_item(CMD_SAMPLE, 4'd15, 12'd0);
		send_item(CMD_NONE, 4'd3, 12'hABC);
		drain();
		write_reg(REG_CALIBRATE, 15'd1);
		write_reg(REG_ALPHA, 15'd256);
		send_item(CMD_SAMPLE, 4'd1, 12'hFFF);
		send_item(CMD_SAMPLE, 4'd1, 12'd0);
		send_item(CMD_SAMPLE, 4'd1, 12'd2048);
		send_item(CMD_ZERO, 4'd1, 12'd0);
		send_item(CMD_SAMPLE, 4'd1, 12'd0);
		send_item(CMD_SAMPLE, 4'd1, 12'hFFF);
		drain();
		write_reg(REG_CALIBRATE, 15'd0);
		write_reg(REG_ALPHA, 15'd0);
		write_reg(REG_DEAD_ZONE, 15'd4095);
		write_reg(REG_TRIM, 15'h1001);
		write_reg(REG_FULL, 15'd32767);
		write_reg(REG_DIVIDER, 15'd0);
		write_reg(REG_DIRECTION, 15'h0002);
		send_item(CMD_SAMPLE, 4'd1, 12'd100);
		drain();
		write_reg(REG_ALPHA, 15'd511);
		write_reg(REG_DEAD_ZONE, 15'd0);
		write_reg(REG_TRIM, 15'd4095);
		write_reg(REG_DIVIDER, 15'd255);
		write_reg(REG_DIRECTION, 15'h0003);
		send_item(CMD_SAMPLE, 4'd1, 12'd4000);
		send_item(CMD_SAMPLE, 4'd1, 12'd10);
		drain();
		write_reg(REG_DIVIDER, 15'd1);
		write_reg(REG_DIRECTION, 15'd1);
		write_reg(REG_FULL, 15'd1);
		send_item(CMD_SAMPLE, 4'd1, 12'd3000);
		send_item(CMD_LIMITS, 4'd1, 12'd0);
		send_item(CMD_SAMPLE, 4'd1, 12'd3000);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_CALIBRATE, 15'd1);
			write_reg(REG_ALPHA, 15'($urandom_range(64, 256)));
			random_burst(50);
			drain();
			write_reg(REG_CALIBRATE, 15'd0);
			random_settings(ph % 4 == 3);
			random_burst(100);
			drain();
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(3) == 0 ? 0 : $urandom_range(18);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result({m_tdata[3:0], m_tdata[15:4], m_tdata[31:16], m_tdata[47:32],
				m_tdata[63:48], m_tuser});
		end
	end
endmodule

[joystick_axis_calibrator.f]
rtl/core/jac_pkg.sv
rtl/core/jac_regs.sv
rtl/core/jac_div.sv
rtl/core/jac_datapath.sv
rtl/core/jac_ctrl.sv
rtl/core/joystick_axis_calibrator.sv
tb/joystick_axis_calibrator_test.sv
